@@ hdl/uist_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package uist_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 8;
  localparam int CMD_W   = 2;

  // Command codes; any other code behaves as a membership test
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic                     status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] min_value;
    logic                     min_valid;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input transaction, clear the scan state
    logic scan_rd;   // read the entry at the scan index, advance the index
    logic commit;    // end of scan: append on add, latch the outcome flags
    logic rd_last;   // read the last used entry
    logic move;      // copy the last entry into the removed slot, shrink
    logic out_load;  // load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;       // scan index is below the fill count
    logic scan_vld;   // a scan read is still in flight
    logic do_remove;  // remove command whose value was found
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/uist_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module uist_dp #(
  parameter int CAPACITY = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  uist_pkg::dp_cmd_t cmd_i,
  output uist_pkg::dp_sts_t sts_o,
  input  uist_pkg::in_t     in_data,
  output uist_pkg::out_t    out_data
);
  import uist_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic [CW-1:0]            fill_r;
  logic [CW-1:0]            idx_r;
  logic                     scan_vld_r;
  logic [CMD_W-1:0]         cmd_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_idx_r;
  logic                     found_r;
  logic [AW-1:0]            slot_r;
  logic signed [DATA_W-1:0] min_all_r;
  logic                     min_all_vld_r;
  logic signed [DATA_W-1:0] min_ex_r;
  logic                     min_ex_vld_r;
  logic                     added_r;
  logic                     removed_r;
  logic                     reject_r;
  out_t                     out_r;
  out_t                     out_nxt;

  logic                     is_add;
  logic                     room;
  logic                     do_add;
  logic                     do_remove;
  logic [CW-1:0]            fill_m1;
  logic                     mem_we;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     mem_re;
  logic [AW-1:0]            rd_addr;
  logic                     hit;
  logic                     fill_nz;
  logic signed [DATA_W-1:0] min_sel;

  assign is_add    = (cmd_r == CMD_ADD);
  assign room      = (fill_r < CW'(CAPACITY));
  assign do_add    = is_add && !found_r && room;
  assign do_remove = (cmd_r == CMD_REMOVE) && found_r;
  assign fill_m1   = fill_r - 1'b1;

  assign sts_o.more      = (idx_r != fill_r);
  assign sts_o.scan_vld  = scan_vld_r;
  assign sts_o.do_remove = do_remove;

  assign mem_we  = (cmd_i.commit && do_add) || cmd_i.move;
  assign wr_addr = cmd_i.move ? slot_r : fill_r[AW-1:0];
  assign wr_data = cmd_i.move ? rd_data_r : val_r;
  assign mem_re  = cmd_i.scan_rd || cmd_i.rd_last;
  assign rd_addr = cmd_i.rd_last ? fill_m1[AW-1:0] : idx_r[AW-1:0];

  assign hit = (rd_data_r == val_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= idx_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd_i.scan_rd;
      if (cmd_i.commit && do_add) begin
        fill_r <= fill_r + 1'b1;
      end else if (cmd_i.move) begin
        fill_r <= fill_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r         <= in_data.cmd;
      val_r         <= in_data.value;
      idx_r         <= '0;
      found_r       <= 1'b0;
      min_all_vld_r <= 1'b0;
      min_ex_vld_r  <= 1'b0;
    end
    if (cmd_i.scan_rd) begin
      idx_r <= idx_r + 1'b1;
    end
    // Track the match and two minimums: over all entries and over all but the match
    if (scan_vld_r) begin
      if (hit) begin
        found_r <= 1'b1;
        slot_r  <= rd_idx_r;
      end
      if (!min_all_vld_r || (rd_data_r < min_all_r)) begin
        min_all_r     <= rd_data_r;
        min_all_vld_r <= 1'b1;
      end
      if (!hit && (!min_ex_vld_r || (rd_data_r < min_ex_r))) begin
        min_ex_r     <= rd_data_r;
        min_ex_vld_r <= 1'b1;
      end
    end
    if (cmd_i.commit) begin
      added_r   <= do_add;
      removed_r <= do_remove;
      reject_r  <= is_add && !found_r && !room;
    end
    if (cmd_i.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign fill_nz = (fill_r != '0);

  always_comb begin
    if (removed_r) begin
      min_sel = min_ex_r;
    end else if (added_r) begin
      min_sel = (min_all_vld_r && (min_all_r < val_r)) ? min_all_r : val_r;
    end else begin
      min_sel = min_all_r;
    end
    out_nxt.found     = found_r;
    out_nxt.status    = reject_r;
    out_nxt.count     = COUNT_W'(fill_r);
    out_nxt.is_empty  = !fill_nz;
    out_nxt.min_value = fill_nz ? min_sel : '0;
    out_nxt.min_valid = fill_nz;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ hdl/uist_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module uist_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output uist_pkg::dp_cmd_t cmd_o,
  input  uist_pkg::dp_sts_t sts_i
);
  import uist_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_RDLAST = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.more) begin
          cmd_o.scan_rd = 1'b1;
        end else if (!sts_i.scan_vld) begin
          cmd_o.commit = 1'b1;
          state_nxt    = sts_i.do_remove ? S_RDLAST : S_RESULT;
        end
      end
      S_RDLAST: begin
        cmd_o.rd_last = 1'b1;
        state_nxt     = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        // Hold until the result register is free or drains this cycle
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd_o.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/unordered_integer_set_table_core.sv @@
// Set of distinct signed 32-bit integers held unordered in a table of CAPACITY
// entries with a fill count.
// Input channel (in_valid / in_stall / in_data): one transaction carries a
// command (add, remove, test; any other code tests) and a value.
// Result channel (out_valid / out_stall / out_data): one transaction per input
// with found-before, full-reject status, count after, empty flag and minimum.
// The result follows a single-port table scan, one entry per cycle, which does
// the lookup and both minimums; a remove that hits then reads the last entry and
// moves it into the freed slot before the result loads. The next input can be
// taken in the cycle after the result loads.
// One transaction is worked at a time; in_stall is high from acceptance until
// the result is loaded into the output register. A new input is accepted while
// that result still waits, so a stalled receiver holds only the next result.
// The result holds steady while out_stall is high.
// Reset empties the set at once (fill count cleared, no table sweep) and drops
// any pending result.
`timescale 1ns / 1ps
`default_nettype none

module unordered_integer_set_table_core #(
  parameter int CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  uist_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output uist_pkg::out_t out_data
);
  import uist_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  uist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (dp_cmd),
    .sts_i     (dp_sts)
  );

  uist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (dp_cmd),
    .sts_o    (dp_sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/uist_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module uist_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input uist_pkg::out_t out_data
);
  import uist_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_min_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == !out_data.min_valid))
    else $error("empty flag and minimum valid disagree");

  a_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.min_valid |-> (out_data.min_value == '0))
    else $error("minimum of empty set not zero");

  a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> !out_data.found && !out_data.is_empty)
    else $error("rejected add on a present value or empty set");

endmodule

bind unordered_integer_set_table_core uist_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
